FILE: rtl/bgwa_pkg.sv
// bgwa_pkg: shared widths, constants and types of the battery gauge window averager.
// No dependencies; imported by every module of the block.
package bgwa_pkg;

  // field widths
  localparam int RAW_W       = 12;
  localparam int MV_W        = 13;
  localparam int PCT_W       = 7;

  // converter scaling: pin mV = raw * PIN_FULL_MV / ADC_FULL_CODE
  localparam int PIN_FULL_MV   = 3300;
  localparam int ADC_FULL_CODE = 4095;
  localparam int SCALE_W       = 24;  // raw * 3300 fits 24 bits
  localparam int SCALE_SHIFT   = 12;  // 4095 = 2^12 - 1

  // charge curve arithmetic
  localparam int SEG_D_W     = 9;   // offset inside a segment, below 400
  localparam int NUM_W       = 5;   // segment percent span, up to 20
  localparam int PROD_W      = 14;  // offset times span, below 4096
  localparam int RECIP_W     = 15;  // reciprocal of a segment mV span
  localparam int RECIP_SHIFT = 21;  // reciprocals scaled by 2^21, exact below 4096

  // knee voltages of the Li-Po curve, battery mV
  localparam logic [MV_W-1:0] KNEE_FULL = 13'd4200;
  localparam logic [MV_W-1:0] KNEE_90   = 13'd4060;
  localparam logic [MV_W-1:0] KNEE_75   = 13'd3920;
  localparam logic [MV_W-1:0] KNEE_55   = 13'd3800;
  localparam logic [MV_W-1:0] KNEE_40   = 13'd3700;
  localparam logic [MV_W-1:0] KNEE_25   = 13'd3600;
  localparam logic [MV_W-1:0] KNEE_10   = 13'd3400;
  localparam logic [MV_W-1:0] KNEE_0    = 13'd3000;

  localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

  // defaults
  localparam int               WINDOW_LEN_DEF = 16;
  localparam logic [MV_W-1:0]  CRIT_RESET     = 13'd3300;

  // queue status seen by the front and back parts
  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

FILE: rtl/bgwa_front.sv
// bgwa_front: accepts sample words, scales good readings to pin mV and sums each window.
// Depends on bgwa_pkg; pushes {sum, good count} of each non-empty window into the queue.
module bgwa_front import bgwa_pkg::*; #(
  parameter int WINDOW_LEN = WINDOW_LEN_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [RAW_W-1:0]     in_raw_sample,
  input  logic                 in_read_ok,
  input  fifo_stat_t           fifo_stat,
  output logic                 push,
  output logic [$clog2(PIN_FULL_MV*WINDOW_LEN+1)+$clog2(WINDOW_LEN+1)-1:0] push_data
);

  localparam int SUM_W = $clog2(PIN_FULL_MV * WINDOW_LEN + 1);
  localparam int CNT_W = $clog2(WINDOW_LEN + 1);

  logic                 busy_r;
  logic [SCALE_W-1:0]   prod_r;
  logic                 ok_r;
  logic [SUM_W-1:0]     sum_r, sum_nxt;
  logic [CNT_W-1:0]     good_r, good_nxt;
  logic [CNT_W-1:0]     att_r;
  logic                 accept;
  logic                 win_end;
  logic [RAW_W-1:0]     q0;
  logic [RAW_W:0]       rem;
  logic [RAW_W-1:0]     mv;

  // one word in flight; the queue must have room before a word is taken
  assign in_stall = busy_r | fifo_stat.full;
  assign accept   = in_valid & ~in_stall;

  // stage 1: raw * 3300
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= accept;
    end
    if (accept) begin
      prod_r <= SCALE_W'(in_raw_sample) * SCALE_W'(PIN_FULL_MV);
      ok_r   <= in_read_ok;
    end
  end

  // stage 2: divide by 4095 = 2^12-1: estimate by shift, one correction
  assign q0  = prod_r[SCALE_W-1 -: RAW_W];
  assign rem = {1'b0, prod_r[SCALE_SHIFT-1:0]} + {1'b0, q0};
  assign mv  = (rem >= (RAW_W+1)'(ADC_FULL_CODE)) ? q0 + RAW_W'(1) : q0;

  assign sum_nxt  = ok_r ? sum_r + SUM_W'(mv) : sum_r;
  assign good_nxt = ok_r ? good_r + CNT_W'(1) : good_r;
  assign win_end  = (att_r == CNT_W'(WINDOW_LEN - 1));

  assign push      = busy_r & win_end & (good_nxt != '0);
  assign push_data = {sum_nxt, good_nxt};

  // window accumulators
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r  <= '0;
      good_r <= '0;
      att_r  <= '0;
    end else if (busy_r) begin
      if (win_end) begin
        sum_r  <= '0;
        good_r <= '0;
        att_r  <= '0;
      end else begin
        sum_r  <= sum_nxt;
        good_r <= good_nxt;
        att_r  <= att_r + CNT_W'(1);
      end
    end
  end

endmodule

FILE: rtl/bgwa_fifo.sv
// bgwa_fifo: two-entry queue between the front and back parts.
// Depends on bgwa_pkg for the status struct.
module bgwa_fifo import bgwa_pkg::*; #(
  parameter int W = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wr_data,
  input  logic         pop,
  output logic [W-1:0] rd_data,
  output fifo_stat_t   stat
);

  logic [W-1:0] mem [2];
  logic         wr_ptr_r, rd_ptr_r;
  logic [1:0]   cnt_r;

  assign stat.full  = (cnt_r == 2'd2);
  assign stat.empty = (cnt_r == 2'd0);
  assign rd_data    = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

FILE: rtl/bgwa_div.sv
// bgwa_div: restoring divider, one quotient bit a cycle.
// Depends on bgwa_pkg; used by the back part for the window average.
module bgwa_div import bgwa_pkg::*; #(
  parameter int DW = 16,
  parameter int VW = 9
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int CW = $clog2(DW + 1);

  logic          busy_r, done_r;
  logic [CW-1:0] cnt_r;
  logic [DW-1:0] quo_r;
  logic [VW-1:0] rem_r;
  logic [VW-1:0] div_r;
  logic [VW:0]   rem_sh;
  logic [VW+1:0] diff;
  logic          ge;

  // trial subtract of the shifted remainder
  assign rem_sh = {rem_r, quo_r[DW-1]};
  assign diff   = {1'b0, rem_sh} - {2'b0, div_r};
  assign ge     = ~diff[VW+1];

  assign done     = done_r;
  assign quotient = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(DW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      div_r <= divisor;
    end else if (busy_r) begin
      rem_r <= ge ? diff[VW-1:0] : rem_sh[VW-1:0];
      quo_r <= {quo_r[DW-2:0], ge};
    end
  end

endmodule

FILE: rtl/bgwa_back.sv
// bgwa_back: takes window sums from the queue, averages, maps to percent, holds the result.
// Depends on bgwa_pkg and bgwa_div.
module bgwa_back import bgwa_pkg::*; #(
  parameter int WINDOW_LEN = WINDOW_LEN_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  fifo_stat_t        fifo_stat,
  input  logic [$clog2(PIN_FULL_MV*WINDOW_LEN+1)+$clog2(WINDOW_LEN+1)-1:0] pop_data,
  output logic              pop,
  input  logic [MV_W-1:0]   critical_mv,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [MV_W-1:0]   out_battery_mv,
  output logic [PCT_W-1:0]  out_charge_percent,
  output logic              out_battery_ok
);

  localparam int SUM_W  = $clog2(PIN_FULL_MV * WINDOW_LEN + 1);
  localparam int CNT_W  = $clog2(WINDOW_LEN + 1);
  localparam int FRAC_W = PROD_W + RECIP_W;

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_DIV_AVG = 6'b000010,
    ST_SEG     = 6'b000100,
    ST_PROD    = 6'b001000,
    ST_PCT     = 6'b010000,
    ST_HOLD    = 6'b100000
  } back_state_t;

  back_state_t        state_r, state_nxt;
  logic [MV_W-1:0]    bat_r;
  logic [SEG_D_W-1:0] d_r;
  logic [NUM_W-1:0]   num_r;
  logic [RECIP_W-1:0] rcp_r;
  logic [PCT_W-1:0]   base_r;
  logic [PROD_W-1:0]  prod_r;
  logic [PCT_W-1:0]   pct_r;
  logic               out_valid_r;
  logic [MV_W-1:0]    out_mv_r;
  logic [PCT_W-1:0]   out_pct_r;
  logic               out_ok_r;

  logic               div_start, div_done;
  logic [SUM_W-1:0]   div_dividend, div_quo;
  logic [CNT_W-1:0]   div_divisor;
  logic [FRAC_W-1:0]  frac;
  logic [MV_W-1:0]    seg_mv, seg_diff;
  logic [NUM_W-1:0]   seg_num;
  logic [RECIP_W-1:0] seg_rcp;
  logic [PCT_W-1:0]   seg_base;
  logic               load_out;

  bgwa_div #(.DW(SUM_W), .VW(CNT_W)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  // segment of the charge curve; flat ends use a zero span
  // reciprocals are 2^21 over the segment mV span, rounded up
  always_comb begin
    seg_mv   = bat_r;
    seg_num  = '0;
    seg_rcp  = '0;
    seg_base = '0;
    if (bat_r >= KNEE_FULL) begin
      seg_base = PCT_FULL;
    end else if (bat_r >= KNEE_90) begin
      seg_mv = KNEE_90; seg_base = 7'd90; seg_num = 5'd10; seg_rcp = 15'd14980;
    end else if (bat_r >= KNEE_75) begin
      seg_mv = KNEE_75; seg_base = 7'd75; seg_num = 5'd15; seg_rcp = 15'd14980;
    end else if (bat_r >= KNEE_55) begin
      seg_mv = KNEE_55; seg_base = 7'd55; seg_num = 5'd20; seg_rcp = 15'd17477;
    end else if (bat_r >= KNEE_40) begin
      seg_mv = KNEE_40; seg_base = 7'd40; seg_num = 5'd15; seg_rcp = 15'd20972;
    end else if (bat_r >= KNEE_25) begin
      seg_mv = KNEE_25; seg_base = 7'd25; seg_num = 5'd15; seg_rcp = 15'd20972;
    end else if (bat_r >= KNEE_10) begin
      seg_mv = KNEE_10; seg_base = 7'd10; seg_num = 5'd15; seg_rcp = 15'd10486;
    end else if (bat_r >= KNEE_0) begin
      seg_mv = KNEE_0;  seg_base = 7'd0;  seg_num = 5'd10; seg_rcp = 15'd5243;
    end
  end
  assign seg_diff = bat_r - seg_mv;

  // in-segment fraction by reciprocal multiplication
  assign frac = FRAC_W'(prod_r) * FRAC_W'(rcp_r);

  // divider operands: window sum over good count, taken as the word is popped
  assign div_dividend = pop_data[CNT_W +: SUM_W];
  assign div_divisor  = pop_data[CNT_W-1:0];
  assign div_start    = pop;

  assign pop      = (state_r == ST_IDLE) & ~fifo_stat.empty;
  assign load_out = (state_r == ST_HOLD) & (~out_valid_r | ~out_stall);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:    if (!fifo_stat.empty) state_nxt = ST_DIV_AVG;
      ST_DIV_AVG: if (div_done) state_nxt = ST_SEG;
      ST_SEG:     state_nxt = ST_PROD;
      ST_PROD:    state_nxt = ST_PCT;
      ST_PCT:     state_nxt = ST_HOLD;
      ST_HOLD:    if (load_out) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (state_r == ST_DIV_AVG && div_done) begin
      bat_r <= {div_quo[MV_W-2:0], 1'b0};
    end
    if (state_r == ST_SEG) begin
      d_r    <= seg_diff[SEG_D_W-1:0];
      num_r  <= seg_num;
      rcp_r  <= seg_rcp;
      base_r <= seg_base;
    end
    if (state_r == ST_PROD) begin
      prod_r <= PROD_W'(d_r) * PROD_W'(num_r);
    end
    if (state_r == ST_PCT) begin
      pct_r <= base_r + PCT_W'(frac[RECIP_SHIFT +: NUM_W]);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (load_out) begin
      out_mv_r  <= bat_r;
      out_pct_r <= pct_r;
      out_ok_r  <= (bat_r > critical_mv);
    end
  end

  assign out_valid          = out_valid_r;
  assign out_battery_mv     = out_mv_r;
  assign out_charge_percent = out_pct_r;
  assign out_battery_ok     = out_ok_r;

endmodule

FILE: rtl/battery_gauge_window_average_unit.sv
// battery_gauge_window_average_unit: top level of the battery gauge window averager.
// Depends on bgwa_pkg, bgwa_front, bgwa_fifo, bgwa_back (with bgwa_div).
//
// Input words carry one 12-bit converter sample and a read-ok flag (in_valid/in_stall).
// Every WINDOW_LEN words close a window; a window with at least one good sample
// yields one result word on out_valid/out_stall: battery mV, charge percent and an
// ok flag against critical_mv. A window with no good sample yields nothing.
// critical_mv is written over cfg_valid/cfg_ready (always ready); the user must write it
// only while the block is idle, which the block itself does not enforce. The two-stage
// scaling path holds one word at a time, so a new word is taken only after the last has
// left it. With an idle output register, out_valid rises once the serial divider, one bit
// a cycle over the window sum width (16 at the default window), has formed the average
// and the charge curve has been applied by reciprocal multiplication in ST_SEG to ST_PCT.
// A two-entry queue lets the front keep taking words while the back works or the
// receiver stalls; when the queue is full the front raises in_stall. A stalled result
// stays on the outputs unchanged. Synchronous active-low reset empties the queue,
// clears the window sums and sets critical_mv to 3300.
module battery_gauge_window_average_unit import bgwa_pkg::*; #(
  parameter int WINDOW_LEN = WINDOW_LEN_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [RAW_W-1:0]  in_raw_sample,
  input  logic              in_read_ok,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [MV_W-1:0]   out_battery_mv,
  output logic [PCT_W-1:0]  out_charge_percent,
  output logic              out_battery_ok,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [MV_W-1:0]   cfg_critical_mv
);

  localparam int SUM_W = $clog2(PIN_FULL_MV * WINDOW_LEN + 1);
  localparam int CNT_W = $clog2(WINDOW_LEN + 1);
  localparam int Q_W   = SUM_W + CNT_W;

  logic [MV_W-1:0] crit_r;
  logic            push, pop;
  logic [Q_W-1:0]  push_data, pop_data;
  fifo_stat_t      fifo_stat;

  // threshold register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crit_r <= CRIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      crit_r <= cfg_critical_mv;
    end
  end

  bgwa_front #(.WINDOW_LEN(WINDOW_LEN)) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_raw_sample (in_raw_sample),
    .in_read_ok    (in_read_ok),
    .fifo_stat     (fifo_stat),
    .push          (push),
    .push_data     (push_data)
  );

  bgwa_fifo #(.W(Q_W)) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_data (push_data),
    .pop     (pop),
    .rd_data (pop_data),
    .stat    (fifo_stat)
  );

  bgwa_back #(.WINDOW_LEN(WINDOW_LEN)) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .fifo_stat          (fifo_stat),
    .pop_data           (pop_data),
    .pop                (pop),
    .critical_mv        (crit_r),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_battery_mv     (out_battery_mv),
    .out_charge_percent (out_charge_percent),
    .out_battery_ok     (out_battery_ok)
  );

  // queue never written when full nor read when empty
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !fifo_stat.full) else $error("window queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !fifo_stat.empty) else $error("window queue underflow");

  // a result is an even voltage in range with a percentage of at most 100
  a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_battery_mv[0] == 1'b0) && (out_battery_mv <= 13'd6600) &&
                  (out_charge_percent <= PCT_FULL))
    else $error("result out of range");

endmodule
